[src/gf2br_pkg.sv]
// Shared types and codes for the GF(2) basis reduce-and-express block.
package gf2br_pkg;

    // Operation codes carried in the mode field of an input item.
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int unsigned ITEM_VEC_BITS = 16;
    localparam int unsigned RANK_BITS     = 5;
    localparam int unsigned COMB_BITS     = 16;

    typedef struct packed {
        logic [1:0]               mode;
        logic [ITEM_VEC_BITS-1:0] vector;
    } t_in_item;

    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic                 independent;
        logic [COMB_BITS-1:0] combination;
        logic                 in_span;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic is_query;
        logic lead_found;
    } t_step_flags;

endpackage

[src/gf2br_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module gf2br_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/gf2br_step.sv]
// One reduction step: applies a single basis slot to the working vector.
module gf2br_step #(
    parameter int VEC_BITS = 16
) (
    input  logic [VEC_BITS-1:0]            i_v,
    input  logic [VEC_BITS-1:0]            i_slot,
    input  logic                           i_slot_valid,
    input  logic [$clog2(VEC_BITS)-1:0]    i_idx,
    input  logic [$clog2(VEC_BITS+1)-1:0]  i_pos,
    input  logic [gf2br_pkg::COMB_BITS-1:0] i_used,
    input  logic [$clog2(VEC_BITS)-1:0]    i_lead,
    input  gf2br_pkg::t_step_flags         i_flags,
    output logic [VEC_BITS-1:0]            o_v,
    output logic [$clog2(VEC_BITS+1)-1:0]  o_pos,
    output logic [gf2br_pkg::COMB_BITS-1:0] o_used,
    output logic [$clog2(VEC_BITS)-1:0]    o_lead,
    output gf2br_pkg::t_step_flags         o_flags
);
    import gf2br_pkg::*;

    localparam int PW = $clog2(VEC_BITS + 1);

    logic hit;

    always_comb begin
        hit    = i_slot_valid && i_v[i_idx];
        o_v    = hit ? (i_v ^ i_slot) : i_v;
        o_pos  = i_pos + PW'(i_slot_valid);
        o_used = i_used;
        if (hit && (32'(i_pos) < 32'(COMB_BITS))) begin
            o_used[4'(i_pos)] = 1'b1;
        end
        // Once this slot is applied, bit i_idx is final, so the first set
        // bit met from the top is the leading bit of the remainder.
        o_flags = i_flags;
        o_lead  = i_lead;
        if (!i_flags.is_query && !i_flags.lead_found && o_v[i_idx]) begin
            o_flags.lead_found = 1'b1;
            o_lead             = i_idx;
        end
    end

endmodule

[src/gf2_basis_reduce_and_express.sv]
// Top level of the GF(2) basis reduce-and-express block.
// This block keeps an echelon basis of VEC_BITS-wide bit vectors over GF(2),
// one slot per leading bit, and answers one result transfer for every input
// transfer. A clear empties the basis, an insert reduces the vector by the
// basis from the top slot down and stores any nonzero remainder, and a query
// reduces the vector the same way and reports which basis vectors (numbered
// in descending order) express it, or flags that it lies outside the span.
// An insert or query is accepted in the idle state and then scans the basis
// from the top slot down: one basis slot per cycle is read from the slot RAM
// and applied by the single shared reduction step, with each read issued one
// slot ahead of the step that uses it to cover the RAM read latency. A finish
// state then writes back any new slot and registers the result. A clear or
// the unused mode goes from idle straight to the finish state. The block
// accepts a new item only while idle, but a finished result may wait in the
// output register while the next item is accepted; the write-back cycle
// waits as long as an earlier result is still held there. There is no
// clearing pass after reset: per-slot valid bits mark the occupied slots.
module gf2_basis_reduce_and_express #(
    parameter int VEC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  gf2br_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output gf2br_pkg::t_out_item  o_out_item
);
    import gf2br_pkg::*;

    localparam int AW = $clog2(VEC_BITS);
    localparam int PW = $clog2(VEC_BITS + 1);

    // Sequencer and working registers.
    t_state                r_state, n_state;
    logic [1:0]            r_mode, n_mode;
    logic [VEC_BITS-1:0]   r_v, n_v;
    logic [AW-1:0]         r_addr, n_addr;
    logic                  r_more, n_more;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pidx, n_pidx;
    logic [PW-1:0]         r_pos, n_pos;
    logic [COMB_BITS-1:0]  r_used, n_used;
    logic [AW-1:0]         r_lead, n_lead;
    logic                  r_lead_found, n_lead_found;

    // Basis bookkeeping: a valid bit per slot and the rank.
    logic [VEC_BITS-1:0]   r_valid, n_valid;
    logic [PW-1:0]         r_count, n_count;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item, n_out_item;

    // Slot RAM and shared step connections.
    logic                  ram_we;
    logic [VEC_BITS-1:0]   ram_rdata;
    logic [VEC_BITS-1:0]   step_v;
    logic [PW-1:0]         step_pos;
    logic [COMB_BITS-1:0]  step_used;
    logic [AW-1:0]         step_lead;
    t_step_flags           step_flags_in, step_flags_out;
    logic                  in_xfer;
    logic                  is_insert, is_query, span_hit;

    gf2br_ram #(
        .WIDTH (VEC_BITS),
        .DEPTH (VEC_BITS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lead),
        .i_wdata (r_v),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign step_flags_in.is_query   = (r_mode == MODE_QUERY);
    assign step_flags_in.lead_found = r_lead_found;

    gf2br_step #(
        .VEC_BITS (VEC_BITS)
    ) u_step (
        .i_v          (r_v),
        .i_slot       (ram_rdata),
        .i_slot_valid (r_valid[r_pidx]),
        .i_idx        (r_pidx),
        .i_pos        (r_pos),
        .i_used       (r_used),
        .i_lead       (r_lead),
        .i_flags      (step_flags_in),
        .o_v          (step_v),
        .o_pos        (step_pos),
        .o_used       (step_used),
        .o_lead       (step_lead),
        .o_flags      (step_flags_out)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign is_insert = (r_mode == MODE_INSERT);
    assign is_query  = (r_mode == MODE_QUERY);
    assign span_hit  = is_query && (r_v == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_more       <= 1'b0;
            r_lead_found <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend       <= n_pend;
            r_more       <= n_more;
            r_lead_found <= n_lead_found;
        end
        r_mode     <= n_mode;
        r_v        <= n_v;
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_pos      <= n_pos;
        r_used     <= n_used;
        r_lead     <= n_lead;
        r_out_item <= n_out_item;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_v          = r_v;
        n_addr       = r_addr;
        n_more       = r_more;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_pos        = r_pos;
        n_used       = r_used;
        n_lead       = r_lead;
        n_lead_found = r_lead_found;
        n_valid      = r_valid;
        n_count      = r_count;
        n_out_item   = r_out_item;
        n_out_valid  = r_out_valid && !i_out_ready;
        ram_we       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_mode       = i_in_item.mode;
                    n_v          = VEC_BITS'(64'(i_in_item.vector));
                    n_addr       = AW'(VEC_BITS - 1);
                    n_more       = 1'b1;
                    n_pend       = 1'b0;
                    n_pos        = '0;
                    n_used       = '0;
                    n_lead       = '0;
                    n_lead_found = 1'b0;
                    if ((i_in_item.mode == MODE_INSERT) ||
                        (i_in_item.mode == MODE_QUERY)) begin
                        n_state = ST_SCAN;
                    end else begin
                        // Clear takes effect at once; the unused code only
                        // reports the current rank.
                        if (i_in_item.mode == MODE_CLEAR) begin
                            n_valid = '0;
                            n_count = '0;
                        end
                        n_state = ST_FINISH;
                    end
                end
            end

            ST_SCAN: begin
                // Reads are issued one slot ahead of the step that uses them.
                if (r_pend) begin
                    n_v          = step_v;
                    n_pos        = step_pos;
                    n_used       = step_used;
                    n_lead       = step_lead;
                    n_lead_found = step_flags_out.lead_found;
                end
                n_pidx = r_addr;
                n_pend = r_more;
                if (r_more) begin
                    if (r_addr == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_addr = r_addr - AW'(1);
                    end
                end
                if (r_pend && (r_pidx == '0)) begin
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    if (is_insert && r_lead_found) begin
                        ram_we          = 1'b1;
                        n_valid[r_lead] = 1'b1;
                        n_count         = r_count + PW'(1);
                    end
                    n_out_item.rank        = RANK_BITS'(n_count);
                    n_out_item.independent = is_insert && r_lead_found;
                    n_out_item.combination = span_hit ? r_used : '0;
                    n_out_item.in_span     = span_hit;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The rank always matches the number of occupied slots.
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("rank differs from number of occupied slots");

    // The rank never exceeds the number of slots.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= VEC_BITS)
        else $error("rank exceeds slot count");

    // A clear transfer empties the basis on the next cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_item.mode == MODE_CLEAR)) |=> (r_valid == '0))
        else $error("clear did not empty the basis");

    // A new result is loaded only when the output register is free or drained.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !i_out_ready) |=> (r_state == ST_FINISH))
        else $error("result finished while output register was held");
`endif

endmodule
